FILE: rtl/core/depth_pixel_to_point_core_macros.svh
// ----------------------------------------------------------------------------
// depth_pixel_to_point_core_macros
// Assertion macros shared by the depth-to-point core.
// ----------------------------------------------------------------------------
`ifndef DEPTH_PIXEL_TO_POINT_CORE_MACROS_SVH
`define DEPTH_PIXEL_TO_POINT_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DP2P_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Implication with the delay given by the lat argument.
`define DP2P_ASSERT_LAT(label, clk, rst_n, ante, lat, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> ##lat (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/dp2p_pkg.sv
// ----------------------------------------------------------------------------
// dp2p_pkg
// Types and fixed-point constants of the depth-to-point core.
// ----------------------------------------------------------------------------
package dp2p_pkg;

	localparam int DEPTH_W     = 16;
	localparam int COLOR_W     = 8;
	localparam int CENTER_W    = 16;
	localparam int RECIP_W     = 32;
	localparam int Z_W         = 31;
	localparam int POINT_W     = 32;
	localparam int Z_FRAC      = 16;
	localparam int LOW_W       = 24;
	localparam int FRAC_DROP   = 12;
	localparam int CFG_INDEX_W = 2;
	localparam int LATENCY     = 5;

	localparam logic [Z_W-1:0]     Z_MAX         = 31'h7FFF_FFFF;
	localparam logic [63:0]        Z_ROUND_BIAS  = 64'd1 << (Z_FRAC - 1);
	localparam logic [63:0]        XY_ROUND_BIAS = 64'd1 << 35;
	localparam logic [POINT_W-1:0] POS_LIMIT     = 32'h7FFF_FFFF;
	localparam logic [POINT_W-1:0] NEG_LIMIT     = 32'h8000_0000;

	localparam logic [RECIP_W-1:0]  INVERSE_FOCAL_RST       = 32'd8180890;
	localparam logic [CENTER_W-1:0] CENTER_X_RST            = 16'd5112;
	localparam logic [CENTER_W-1:0] CENTER_Y_RST            = 16'd3832;
	localparam logic [RECIP_W-1:0]  INVERSE_DEPTH_SCALE_RST = 32'd858993;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_INVERSE_FOCAL       = 2'd0,
		REG_CENTER_X            = 2'd1,
		REG_CENTER_Y            = 2'd2,
		REG_INVERSE_DEPTH_SCALE = 2'd3
	} dp2p_reg_t;

	typedef struct packed {
		logic [RECIP_W-1:0]  inverse_focal;
		logic [CENTER_W-1:0] center_x;
		logic [CENTER_W-1:0] center_y;
		logic [RECIP_W-1:0]  inverse_depth_scale;
	} dp2p_cfg_t;

	// Fields that ride alongside the arithmetic without being touched.
	typedef struct packed {
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
		logic               invalid;
	} dp2p_side_t;

endpackage

FILE: rtl/core/depth_pixel_to_point_core.sv
// ----------------------------------------------------------------------------
// depth_pixel_to_point_core
// Pinhole back-projection of one RGB-D pixel to a Q16.16 point with colour.
// ----------------------------------------------------------------------------
// Usage:
//   Drive a pixel (column, row, depth, red, green, blue) with start high; the
//   transaction is taken at any edge where start is high and busy is low.
//   busy stays low: a new pixel may enter on every clock cycle.
//   Each pixel yields one result transaction on point_x/y/z, out_red/green/
//   blue and invalid. done is valid_s5, the valid bit of the last register stage,
//   and the result is taken at the edge where done is high, in input order.
//   Throughput is one pixel per cycle; the pipeline has five register stages:
//   depth scale with the center offset, Z round/saturate, offset times Z,
//   inverse_focal as two partial products, and a final round/saturate stage.
//   There is no output back-pressure: done is a strobe that the receiver
//   must take when it appears.
//   Configuration: cfg_write with cfg_index and cfg_data loads one register
//   per cycle (0 inverse_focal, 1 center_x, 2 center_y, 3 inverse_depth_scale).
//   Write only while no pixel is in flight.
//   Reset (arst_n low) clears all in-flight transactions and loads the
//   default camera registers; no result appears until new pixels enter.
// ----------------------------------------------------------------------------
`include "depth_pixel_to_point_core_macros.svh"

module depth_pixel_to_point_core
	import dp2p_pkg::*;
#(
	parameter int COORD_BITS = 12
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_write,
	input  logic [CFG_INDEX_W-1:0]    cfg_index,
	input  logic [RECIP_W-1:0]        cfg_data,
	input  logic                      start,
	output logic                      busy,
	input  logic [COORD_BITS-1:0]     column,
	input  logic [COORD_BITS-1:0]     row,
	input  logic [DEPTH_W-1:0]        depth,
	input  logic [COLOR_W-1:0]        red,
	input  logic [COLOR_W-1:0]        green,
	input  logic [COLOR_W-1:0]        blue,
	output logic                      done,
	output logic signed [POINT_W-1:0] point_x,
	output logic signed [POINT_W-1:0] point_y,
	output logic [Z_W-1:0]            point_z,
	output logic [COLOR_W-1:0]        out_red,
	output logic [COLOR_W-1:0]        out_green,
	output logic [COLOR_W-1:0]        out_blue,
	output logic                      invalid
);

	dp2p_cfg_t  cfg_q;
	logic       accept;
	logic       valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	dp2p_side_t side_s1, side_s2, side_s3, side_s4, side_s5;
	logic [Z_W-1:0] z_s2, z_s3, z_s4, z_s5;

	// The pipeline never stalls, so a pixel can always enter.
	assign busy   = 1'b0;
	assign accept = start && !busy;

	// Configuration registers; writes to them must happen only when idle, which the block itself does not enforce.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.inverse_focal       <= INVERSE_FOCAL_RST;
			cfg_q.center_x            <= CENTER_X_RST;
			cfg_q.center_y            <= CENTER_Y_RST;
			cfg_q.inverse_depth_scale <= INVERSE_DEPTH_SCALE_RST;
		end else if (cfg_write) begin
			unique case (dp2p_reg_t'(cfg_index))
				REG_INVERSE_FOCAL:       cfg_q.inverse_focal       <= cfg_data;
				REG_CENTER_X:            cfg_q.center_x            <= cfg_data[CENTER_W-1:0];
				REG_CENTER_Y:            cfg_q.center_y            <= cfg_data[CENTER_W-1:0];
				REG_INVERSE_DEPTH_SCALE: cfg_q.inverse_depth_scale <= cfg_data;
				default: ;
			endcase
		end
	end

	// Valid bits: advance one stage per cycle, drop on reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	// Colour and the zero-depth flag travel beside the arithmetic.
	always_ff @(posedge clk) begin
		side_s1.red     <= red;
		side_s1.green   <= green;
		side_s1.blue    <= blue;
		side_s1.invalid <= (depth == '0);
		side_s2         <= side_s1;
		side_s3         <= side_s2;
		side_s4         <= side_s3;
		side_s5         <= side_s4;
	end

	// Z: two stages, then delay it to line up with the lateral axes.
	dp2p_depth u_depth (
		.clk   (clk),
		.cfg   (cfg_q),
		.depth (depth),
		.z_s2  (z_s2)
	);

	always_ff @(posedge clk) begin
		z_s3 <= z_s2;
		z_s4 <= z_s3;
		z_s5 <= z_s4;
	end

	// Lateral axes share the focal reciprocal; each has its own center.
	dp2p_axis #(
		.COORD_BITS (COORD_BITS)
	) u_axis_x (
		.clk           (clk),
		.coord         (column),
		.center        (cfg_q.center_x),
		.inverse_focal (cfg_q.inverse_focal),
		.z_s2          (z_s2),
		.point_s5      (point_x)
	);

	dp2p_axis #(
		.COORD_BITS (COORD_BITS)
	) u_axis_y (
		.clk           (clk),
		.coord         (row),
		.center        (cfg_q.center_y),
		.inverse_focal (cfg_q.inverse_focal),
		.z_s2          (z_s2),
		.point_s5      (point_y)
	);

	// A zero depth gives Z = 0, so the coordinates come out zero by themselves.
	assign done      = valid_s5;
	assign point_z   = z_s5;
	assign out_red   = side_s5.red;
	assign out_green = side_s5.green;
	assign out_blue  = side_s5.blue;
	assign invalid   = side_s5.invalid;

	`DP2P_ASSERT_LAT(a_accept_to_done, clk, arst_n, accept, 5, done, "accepted pixel did not complete")
	`DP2P_ASSERT_NOW(a_done_from_accept, clk, arst_n, done, $past(accept, LATENCY), "result without transaction")
	`DP2P_ASSERT_NOW(a_invalid_zero, clk, arst_n, done && invalid, (point_x == '0) && (point_y == '0) && (point_z == '0), "invalid point not zeroed")
	`DP2P_ASSERT_NOW(a_zero_z_zero_xy, clk, arst_n, done && (point_z == '0), (point_x == '0) && (point_y == '0), "nonzero lateral with zero depth")

endmodule

FILE: rtl/core/dp2p_depth.sv
// ----------------------------------------------------------------------------
// dp2p_depth
// Raw depth to Q15.16 metres: multiply, round half up, saturate (two stages).
// ----------------------------------------------------------------------------
module dp2p_depth
	import dp2p_pkg::*;
(
	input  logic               clk,
	input  dp2p_cfg_t          cfg,
	input  logic [DEPTH_W-1:0] depth,
	output logic [Z_W-1:0]     z_s2
);

	localparam int PROD_W = DEPTH_W + RECIP_W;

	logic [PROD_W-1:0]        prod_s1;
	logic [PROD_W-1:0]        round_sum;
	logic [PROD_W-Z_FRAC-1:0] z_wide;

	always_ff @(posedge clk) begin
		prod_s1 <= PROD_W'(depth) * PROD_W'(cfg.inverse_depth_scale);
	end

	// Sum cannot carry out of PROD_W bits: the product tops out well below.
	assign round_sum = prod_s1 + PROD_W'(Z_ROUND_BIAS);
	assign z_wide    = round_sum[PROD_W-1:Z_FRAC];

	always_ff @(posedge clk) begin
		z_s2 <= z_wide[Z_W] ? Z_MAX : z_wide[Z_W-1:0];
	end

endmodule

FILE: rtl/core/dp2p_axis.sv
// ----------------------------------------------------------------------------
// dp2p_axis
// One lateral axis: (coord - center) * Z * inverse_focal, rounded, saturated.
// ----------------------------------------------------------------------------
module dp2p_axis
	import dp2p_pkg::*;
#(
	parameter int COORD_BITS = 12
) (
	input  logic                      clk,
	input  logic [COORD_BITS-1:0]     coord,
	input  logic [CENTER_W-1:0]       center,
	input  logic [RECIP_W-1:0]        inverse_focal,
	input  logic [Z_W-1:0]            z_s2,
	output logic signed [POINT_W-1:0] point_s5
);

	localparam int SHIFT_W = COORD_BITS + 4;
	localparam int MAG_W   = (SHIFT_W > CENTER_W) ? SHIFT_W : CENTER_W;
	localparam int DIFF_W  = MAG_W + 1;
	localparam int A_W     = MAG_W + Z_W;
	localparam int HI_W    = A_W - LOW_W + RECIP_W;
	localparam int LO_W    = LOW_W + RECIP_W;
	localparam int SUM_W   = HI_W + 1;
	localparam int RES_W   = SUM_W - FRAC_DROP;

	logic [DIFF_W-1:0] diff;
	logic [DIFF_W-1:0] diff_abs;
	logic [MAG_W-1:0]  mag_s1, mag_s2;
	logic              neg_s1, neg_s2, neg_s3, neg_s4;
	logic [A_W-1:0]    a_s3;
	logic [HI_W-1:0]   hi_s4;
	logic [LO_W-1:0]   lo_s4;
	logic [LO_W:0]     lo_round;
	logic [SUM_W-1:0]  sum;
	logic [RES_W-1:0]  res_mag;
	logic              pos_over;
	logic              neg_over;

	// Stage 1: signed Q.4 offset, split into sign and magnitude.
	assign diff     = DIFF_W'({coord, 4'b0000}) - DIFF_W'(center);
	assign diff_abs = diff[DIFF_W-1] ? (DIFF_W'(0) - diff) : diff;

	always_ff @(posedge clk) begin
		mag_s1 <= diff_abs[MAG_W-1:0];
		neg_s1 <= diff[DIFF_W-1];
	end

	// Stage 2: hold the offset until Z is ready.
	always_ff @(posedge clk) begin
		mag_s2 <= mag_s1;
		neg_s2 <= neg_s1;
	end

	// Stage 3: offset times Z.
	always_ff @(posedge clk) begin
		a_s3   <= A_W'(mag_s2) * A_W'(z_s2);
		neg_s3 <= neg_s2;
	end

	// Stage 4: times inverse_focal, in a high and a low partial product.
	always_ff @(posedge clk) begin
		hi_s4  <= HI_W'(a_s3[A_W-1:LOW_W]) * HI_W'(inverse_focal);
		lo_s4  <= LO_W'(a_s3[LOW_W-1:0]) * LO_W'(inverse_focal);
		neg_s4 <= neg_s3;
	end

	// Stage 5: merge, round half away from zero, saturate, restore sign.
	assign lo_round = (LO_W + 1)'(lo_s4) + (LO_W + 1)'(XY_ROUND_BIAS);
	assign sum      = SUM_W'(hi_s4) + SUM_W'(lo_round[LO_W:LOW_W]);
	assign res_mag  = sum[SUM_W-1:FRAC_DROP];
	assign pos_over = res_mag > RES_W'(POS_LIMIT);
	assign neg_over = res_mag > RES_W'(NEG_LIMIT);

	always_ff @(posedge clk) begin
		if (neg_s4) begin
			point_s5 <= neg_over ? NEG_LIMIT : (POINT_W'(0) - res_mag[POINT_W-1:0]);
		end else begin
			point_s5 <= pos_over ? POS_LIMIT : res_mag[POINT_W-1:0];
		end
	end

endmodule
